// File: sv/mcfp_pkg.sv
// ----------------------------------------------------------------------------
// mcfp_pkg
// Shared constants, codes and controller/datapath interface types for the
// motor command frame packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcfp_pkg;

    // parameter defaults
    localparam int MOTORS_DEFAULT        = 16;
    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int OTHER_BITS_DEFAULT    = 12;

    // field widths
    localparam int OP_W    = 3;
    localparam int ID_W    = 11;
    localparam int SLOT_W  = 4;
    localparam int VAL_W   = 32;
    localparam int DATA_W  = 64;
    localparam int CFG_W   = 64;
    localparam int CFGIX_W = 3;
    localparam int CH_W    = 3;
    localparam int CNT_W   = 5;
    localparam int CODE_W  = 16;
    localparam int SLOT_OTHER_W = 12;
    localparam int NUM_W   = VAL_W + CODE_W;

    // command codes
    localparam logic [OP_W-1:0] OP_CONTROL = 3'd0;
    localparam logic [OP_W-1:0] OP_ENTER   = 3'd1;
    localparam logic [OP_W-1:0] OP_EXIT    = 3'd2;
    localparam logic [OP_W-1:0] OP_ZERO    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESEND  = 3'd4;

    // configuration register indexes
    localparam logic [CFGIX_W-1:0] CFG_POSITION = 3'd0;
    localparam logic [CFGIX_W-1:0] CFG_SPEED    = 3'd1;
    localparam logic [CFGIX_W-1:0] CFG_KP       = 3'd2;
    localparam logic [CFGIX_W-1:0] CFG_KD       = 3'd3;
    localparam logic [CFGIX_W-1:0] CFG_TORQUE   = 3'd4;

    // value channels, in packing order
    localparam logic [CH_W-1:0] CH_POSITION = 3'd0;
    localparam logic [CH_W-1:0] CH_SPEED    = 3'd1;
    localparam logic [CH_W-1:0] CH_KP       = 3'd2;
    localparam logic [CH_W-1:0] CH_KD       = 3'd3;
    localparam logic [CH_W-1:0] CH_TORQUE   = 3'd4;

    // result source
    localparam logic [1:0] RES_CTRL  = 2'd0;
    localparam logic [1:0] RES_FIXED = 2'd1;
    localparam logic [1:0] RES_MISS  = 2'd2;
    localparam logic [1:0] RES_SAVED = 2'd3;

    // fixed frames
    localparam logic [DATA_W-1:0] FRAME_ENTER = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [DATA_W-1:0] FRAME_EXIT  = 64'hFFFF_FFFF_FFFF_FFFD;
    localparam logic [DATA_W-1:0] FRAME_ZERO  = 64'hFFFF_FFFF_FFFF_FFFE;

    typedef struct packed {
        logic            capture;
        logic [CH_W-1:0] ch;
        logic            clamp;
        logic            mul;
        logic            dinit;
        logic            dstep;
        logic            pack;
        logic            store;
        logic            rd;
        logic            res_load;
        logic [1:0]      res_sel;
    } mcfp_cmd_t;

    typedef struct packed {
        logic hit;
    } mcfp_status_t;

endpackage

`default_nettype wire

// File: sv/mcfp_ram.sv
// ----------------------------------------------------------------------------
// mcfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/mcfp_datapath.sv
// ----------------------------------------------------------------------------
// mcfp_datapath
// Request and range registers, clamp, scale multiplier, restoring divider,
// payload packing, per-slot frame store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfp_datapath
    import mcfp_pkg::*;
#(
    parameter int MOTORS        = MOTORS_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int OTHER_BITS    = OTHER_BITS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [CFGIX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic [OP_W-1:0]    s_op,
    input  wire logic [ID_W-1:0]    s_motor_id,
    input  wire logic [SLOT_W-1:0]  s_motor_slot,
    input  wire logic [VAL_W-1:0]   s_goal_position,
    input  wire logic [VAL_W-1:0]   s_goal_speed,
    input  wire logic [VAL_W-1:0]   s_stiffness_gain,
    input  wire logic [VAL_W-1:0]   s_damping_gain,
    input  wire logic [VAL_W-1:0]   s_goal_torque,
    input  wire mcfp_cmd_t          cmd,
    output mcfp_status_t            status,
    output logic [ID_W-1:0]         m_frame_id,
    output logic [DATA_W-1:0]       m_frame_data,
    output logic                    m_no_previous
);

    localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic [CODE_W-1:0] TOP_POS   = CODE_W'((1 << POSITION_BITS) - 1);
    localparam logic [CODE_W-1:0] TOP_OTHER = CODE_W'((1 << OTHER_BITS) - 1);

    // configuration
    logic [CFG_W-1:0] pos_rng_reg, spd_rng_reg, kp_rng_reg, kd_rng_reg, trq_rng_reg;

    // captured request
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  pos_reg, spd_reg, kp_reg, kd_reg, trq_reg;

    // arithmetic
    logic [VAL_W-1:0]  d_reg, r_reg, rem_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [CODE_W-1:0] low_reg, q_reg;
    logic [DATA_W-1:0] payload_reg;

    logic [MOTORS-1:0] valid_reg;

    logic [VAL_W-1:0]    val;
    logic [CFG_W-1:0]    rng;
    logic                neg;
    logic signed [32:0]  x, lo, hi, xc;
    logic [33:0]         d_full, r_full;
    logic [CNT_W-1:0]    bits;
    logic [CODE_W-1:0]   top;
    logic [VAL_W:0]      trial;
    logic                ge;
    logic [31:0]         slot_ext;
    logic                slot_ok;
    logic [AW-1:0]       idx;
    logic [ID_W+DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0]   fixed_frame;

    assign slot_ext = 32'(slot_reg);
    assign slot_ok  = slot_ext < 32'(MOTORS);
    assign idx      = slot_ext[AW-1:0];
    assign status.hit = slot_ok && valid_reg[idx];

    always_comb begin
        case (cmd.ch)
            CH_POSITION: begin val = pos_reg; rng = pos_rng_reg; end
            CH_SPEED:    begin val = spd_reg; rng = spd_rng_reg; end
            CH_KP:       begin val = kp_reg;  rng = kp_rng_reg;  end
            CH_KD:       begin val = kd_reg;  rng = kd_rng_reg;  end
            default:     begin val = trq_reg; rng = trq_rng_reg; end
        endcase
        neg  = (cmd.ch == CH_POSITION) || (cmd.ch == CH_SPEED) || (cmd.ch == CH_TORQUE);
        bits = (cmd.ch == CH_POSITION) ? CNT_W'(POSITION_BITS) : CNT_W'(OTHER_BITS);
        top  = (cmd.ch == CH_POSITION) ? TOP_POS : TOP_OTHER;
    end

    // negation at 33 bits so the most negative input stays exact
    always_comb begin
        x  = neg ? -$signed({val[31], val}) : $signed({val[31], val});
        lo = $signed({rng[31], rng[31:0]});
        hi = $signed({rng[63], rng[63:32]});
        if (x < lo) begin
            xc = lo;
        end else if (x > hi) begin
            xc = hi;
        end else begin
            xc = x;
        end
        d_full = 34'(xc) - 34'(lo);
        r_full = 34'(hi) - 34'(lo);
    end

    assign trial = {rem_reg, low_reg[CODE_W-1]};
    assign ge    = trial >= {1'b0, r_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_rng_reg <= '0;
            spd_rng_reg <= '0;
            kp_rng_reg  <= '0;
            kd_rng_reg  <= '0;
            trq_rng_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POSITION: pos_rng_reg <= cfg_data;
                CFG_SPEED:    spd_rng_reg <= cfg_data;
                CFG_KP:       kp_rng_reg  <= cfg_data;
                CFG_KD:       kd_rng_reg  <= cfg_data;
                CFG_TORQUE:   trq_rng_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_op;
            id_reg   <= s_motor_id;
            slot_reg <= s_motor_slot;
            pos_reg  <= s_goal_position;
            spd_reg  <= s_goal_speed;
            kp_reg   <= s_stiffness_gain;
            kd_reg   <= s_damping_gain;
            trq_reg  <= s_goal_torque;
        end
        if (cmd.clamp) begin
            // empty or inverted range forces a zero code
            if (hi <= lo) begin
                d_reg <= '0;
                r_reg <= VAL_W'(1);
            end else begin
                d_reg <= d_full[VAL_W-1:0];
                r_reg <= r_full[VAL_W-1:0];
            end
        end
        if (cmd.mul) begin
            num_reg <= NUM_W'({16'b0, d_reg} * {32'b0, top});
        end
        // quotient fits in bits, so only the top part enters the remainder
        if (cmd.dinit) begin
            rem_reg <= VAL_W'(num_reg >> bits);
            low_reg <= num_reg[CODE_W-1:0] << (CNT_W'(CODE_W) - bits);
            q_reg   <= '0;
        end
        if (cmd.dstep) begin
            rem_reg <= ge ? VAL_W'(trial - {1'b0, r_reg}) : trial[VAL_W-1:0];
            q_reg   <= {q_reg[CODE_W-2:0], ge};
            low_reg <= {low_reg[CODE_W-2:0], 1'b0};
        end
        if (cmd.pack) begin
            if (cmd.ch == CH_POSITION) begin
                payload_reg <= {48'b0, q_reg};
            end else begin
                payload_reg <= {payload_reg[DATA_W-SLOT_OTHER_W-1:0],
                                q_reg[SLOT_OTHER_W-1:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.store && slot_ok) begin
            valid_reg[idx] <= 1'b1;
        end else if (cmd.rd) begin
            valid_reg[idx] <= 1'b0;
        end
    end

    mcfp_ram #(
        .WIDTH (ID_W + DATA_W),
        .DEPTH (MOTORS)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (cmd.store && slot_ok),
        .waddr (idx),
        .wdata ({id_reg, payload_reg}),
        .re    (cmd.rd),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        unique case (op_reg)
            OP_ENTER: fixed_frame = FRAME_ENTER;
            OP_EXIT:  fixed_frame = FRAME_EXIT;
            default:  fixed_frame = FRAME_ZERO;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            unique case (cmd.res_sel)
                RES_CTRL: begin
                    m_frame_id    <= id_reg;
                    m_frame_data  <= payload_reg;
                    m_no_previous <= 1'b0;
                end
                RES_FIXED: begin
                    m_frame_id    <= id_reg;
                    m_frame_data  <= fixed_frame;
                    m_no_previous <= 1'b0;
                end
                RES_MISS: begin
                    m_frame_id    <= id_reg;
                    m_frame_data  <= '0;
                    m_no_previous <= 1'b1;
                end
                default: begin
                    m_frame_id    <= ram_rdata[ID_W+DATA_W-1:DATA_W];
                    m_frame_data  <= ram_rdata[DATA_W-1:0];
                    m_no_previous <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/mcfp_ctrl.sv
// ----------------------------------------------------------------------------
// mcfp_ctrl
// Sequencer: walks the five values through clamp, multiply and divide,
// handles fixed frames and resend, and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfp_ctrl
    import mcfp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int OTHER_BITS    = OTHER_BITS_DEFAULT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [OP_W-1:0] s_op,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire mcfp_status_t    status,
    output mcfp_cmd_t            cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLAMP, ST_MUL, ST_DINIT, ST_DIV, ST_PACK,
        ST_STORE, ST_RESEND, ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       sel_reg, sel_next;
    logic             m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.res_sel = sel_reg;

        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    unique case (s_op) inside
                        OP_CONTROL: begin
                            ch_next    = CH_POSITION;
                            state_next = ST_CLAMP;
                        end
                        OP_ENTER, OP_EXIT, OP_ZERO: begin
                            sel_next   = RES_FIXED;
                            state_next = ST_FINISH;
                        end
                        OP_RESEND: state_next = ST_RESEND;
                        default: ;  // unused codes are dropped
                    endcase
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.dinit  = 1'b1;
                cnt_next   = (ch_reg == CH_POSITION) ? CNT_W'(POSITION_BITS)
                                                     : CNT_W'(OTHER_BITS);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.dstep = 1'b1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_PACK;
                end
            end
            ST_PACK: begin
                cmd.pack = 1'b1;
                if (ch_reg == CH_TORQUE) begin
                    state_next = ST_STORE;
                end else begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = ST_CLAMP;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                sel_next   = RES_CTRL;
                state_next = ST_FINISH;
            end
            ST_RESEND: begin
                cmd.rd     = status.hit;
                sel_next   = status.hit ? RES_SAVED : RES_MISS;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = (m_valid_reg && !m_ready) || cmd.res_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            cnt_reg     <= '0;
            sel_reg     <= RES_CTRL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/motor_command_frame_packer.sv
// ----------------------------------------------------------------------------
// motor_command_frame_packer
// Builds 8-byte motor control frames from Q16.16 commands and keeps the last
// control frame per motor slot for resend.
// ----------------------------------------------------------------------------
// One request at a time. Each of the five values of a control request goes
// through clamp, a 32x16 multiply, and a restoring divider that yields one
// code bit per cycle. Enter, exit and zero load a fixed frame; resend does
// one frame-store read. A finished result sits in an output register, so
// the next request is taken while it waits. Range registers are 64 bits,
// minimum in bits 31..0 and maximum in bits 63..32. The user must write
// them only while the block is idle; the block itself does not enforce this.
`default_nettype none

module motor_command_frame_packer
    import mcfp_pkg::*;
#(
    parameter int MOTORS        = MOTORS_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int OTHER_BITS    = OTHER_BITS_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFGIX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [OP_W-1:0]          s_op,
    input  wire logic [ID_W-1:0]          s_motor_id,
    input  wire logic [SLOT_W-1:0]        s_motor_slot,
    input  wire logic signed [VAL_W-1:0]  s_goal_position,
    input  wire logic signed [VAL_W-1:0]  s_goal_speed,
    input  wire logic signed [VAL_W-1:0]  s_stiffness_gain,
    input  wire logic signed [VAL_W-1:0]  s_damping_gain,
    input  wire logic signed [VAL_W-1:0]  s_goal_torque,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [ID_W-1:0]               m_frame_id,
    output logic [DATA_W-1:0]             m_frame_data,
    output logic                          m_no_previous
);

    mcfp_cmd_t    cmd;
    mcfp_status_t status;

    mcfp_ctrl #(
        .POSITION_BITS (POSITION_BITS),
        .OTHER_BITS    (OTHER_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcfp_datapath #(
        .MOTORS        (MOTORS),
        .POSITION_BITS (POSITION_BITS),
        .OTHER_BITS    (OTHER_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_op             (s_op),
        .s_motor_id       (s_motor_id),
        .s_motor_slot     (s_motor_slot),
        .s_goal_position  (s_goal_position),
        .s_goal_speed     (s_goal_speed),
        .s_stiffness_gain (s_stiffness_gain),
        .s_damping_gain   (s_damping_gain),
        .s_goal_torque    (s_goal_torque),
        .cmd              (cmd),
        .status           (status),
        .m_frame_id       (m_frame_id),
        .m_frame_data     (m_frame_data),
        .m_no_previous    (m_no_previous)
    );

    // a failed resend carries an empty payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_previous |-> m_frame_data == '0)
        else $error("no_previous result with nonzero payload");

    // unused codes are dropped without leaving idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op != OP_CONTROL && s_op != OP_ENTER &&
        s_op != OP_EXIT && s_op != OP_ZERO && s_op != OP_RESEND |=> s_ready)
        else $error("unused command left idle");

    // every real request leaves the block busy in the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_CONTROL || s_op == OP_ENTER ||
        s_op == OP_EXIT || s_op == OP_ZERO || s_op == OP_RESEND) |=> !s_ready)
        else $error("request accepted without going busy");

    // a waiting result stays valid until it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("pending result dropped");

endmodule

`default_nettype wire

// File: tb/sv/motor_command_frame_packer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_command_frame_packer_test
// Drives command requests into the frame packer with random idle and stall
// on both channels, predicts every frame, and checks id, payload and the
// resend miss flag. A short directed table covers reset state, every op,
// range extremes and degenerate ranges. Random phases follow, each under a
// new set of ranges loaded while the block is idle.
// ----------------------------------------------------------------------------
module motor_command_frame_packer_test;
    import mcfp_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int MAX_IDLE        = 18;
    localparam int DRAIN_CYCLES    = 120;
    localparam int LIMIT_CYCLES    = 400_000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 64;

    localparam int KEEP_RANGES       = -1;
    localparam int PRESET_TYPICAL    = 1;
    localparam int PRESET_FULL       = 2;
    localparam int PRESET_DEGENERATE = 3;
    localparam int PRESET_RANDOM     = 4;

    localparam logic [OP_W-1:0]  OP_SPARE_LOW = OP_RESEND + 1'b1;
    localparam logic [OP_W-1:0]  OP_SPARE_TOP = {OP_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;

    typedef logic [CFG_TORQUE:0][CFG_W-1:0] range_bank_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  pos;
        logic [VAL_W-1:0]  spd;
        logic [VAL_W-1:0]  kp;
        logic [VAL_W-1:0]  kd;
        logic [VAL_W-1:0]  trq;
    } cmd_request_t;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
        logic              no_prev;
    } frame_t;

    typedef struct {
        int           preset;
        cmd_request_t req;
        bit           typed;
        frame_t       want;
    } directed_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFGIX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op;
    logic [ID_W-1:0]          s_motor_id;
    logic [SLOT_W-1:0]        s_motor_slot;
    logic signed [VAL_W-1:0]  s_goal_position;
    logic signed [VAL_W-1:0]  s_goal_speed;
    logic signed [VAL_W-1:0]  s_stiffness_gain;
    logic signed [VAL_W-1:0]  s_damping_gain;
    logic signed [VAL_W-1:0]  s_goal_torque;
    logic                     m_valid;
    logic                     m_ready;
    logic [ID_W-1:0]          m_frame_id;
    logic [DATA_W-1:0]        m_frame_data;
    logic                     m_no_previous;

    // predictor state
    range_bank_t   range_regs = '0;
    frame_t        stored_frames [MOTORS_DEFAULT];
    bit            stored_live [MOTORS_DEFAULT];
    frame_t        pending_frames [$];
    directed_row_t directed [$];

    bit send_eager = 1'b0;
    bit take_eager = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int n_requests = 0;
    int n_control = 0;
    int n_resend = 0;
    int n_fixed = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_misses = 0;
    int n_settings = 0;

    motor_command_frame_packer #(
        .MOTORS        (MOTORS_DEFAULT),
        .POSITION_BITS (POSITION_BITS_DEFAULT),
        .OTHER_BITS    (OTHER_BITS_DEFAULT)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_motor_id       (s_motor_id),
        .s_motor_slot     (s_motor_slot),
        .s_goal_position  (s_goal_position),
        .s_goal_speed     (s_goal_speed),
        .s_stiffness_gain (s_stiffness_gain),
        .s_damping_gain   (s_damping_gain),
        .s_goal_torque    (s_goal_torque),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_id       (m_frame_id),
        .m_frame_data     (m_frame_data),
        .m_no_previous    (m_no_previous)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d frames still pending",
                     cycle_count, pending_frames.size());
            $display("FAIL");
            $finish;
        end
    end

    // floor((x-min)*(2^bits-1)/(max-min)) after clamping, zero for an empty or inverted range
    function automatic logic [CODE_W-1:0] quantize(input longint x,
                                                   input logic [CFG_W-1:0] rng,
                                                   input int bits);
        longint lo;
        longint hi;
        longint top;
        lo  = $signed(rng[VAL_W-1:0]);
        hi  = $signed(rng[CFG_W-1:VAL_W]);
        top = (longint'(1) << bits) - 1;
        if (hi <= lo)
            return '0;
        if (x < lo)
            x = lo;
        if (x > hi)
            x = hi;
        return CODE_W'(((x - lo) * top) / (hi - lo));
    endfunction

    function automatic bit predict_frame(input cmd_request_t r, output frame_t f);
        logic [CODE_W-1:0] c_pos;
        logic [CODE_W-1:0] c_spd;
        logic [CODE_W-1:0] c_kp;
        logic [CODE_W-1:0] c_kd;
        logic [CODE_W-1:0] c_trq;
        bit slot_ok;
        slot_ok   = int'(r.slot) < MOTORS_DEFAULT;
        f.id      = r.id;
        f.data    = '0;
        f.no_prev = 1'b0;
        case (r.op)
            OP_CONTROL: begin
                // position, speed and torque are negated at full width first
                c_pos = quantize(-longint'($signed(r.pos)), range_regs[CFG_POSITION],
                                 POSITION_BITS_DEFAULT);
                c_spd = quantize(-longint'($signed(r.spd)), range_regs[CFG_SPEED],
                                 OTHER_BITS_DEFAULT);
                c_kp  = quantize(longint'($signed(r.kp)), range_regs[CFG_KP],
                                 OTHER_BITS_DEFAULT);
                c_kd  = quantize(longint'($signed(r.kd)), range_regs[CFG_KD],
                                 OTHER_BITS_DEFAULT);
                c_trq = quantize(-longint'($signed(r.trq)), range_regs[CFG_TORQUE],
                                 OTHER_BITS_DEFAULT);
                f.data = {c_pos, c_spd[SLOT_OTHER_W-1:0], c_kp[SLOT_OTHER_W-1:0],
                          c_kd[SLOT_OTHER_W-1:0], c_trq[SLOT_OTHER_W-1:0]};
                if (slot_ok) begin
                    stored_frames[r.slot] = f;
                    stored_live[r.slot]   = 1'b1;
                end
            end
            OP_ENTER: f.data = FRAME_ENTER;
            OP_EXIT:  f.data = FRAME_EXIT;
            OP_ZERO:  f.data = FRAME_ZERO;
            OP_RESEND: begin
                if (slot_ok && stored_live[r.slot]) begin
                    f = stored_frames[r.slot];
                    stored_live[r.slot] = 1'b0;
                end else begin
                    f.no_prev = 1'b1;
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic range_bank_t preset_ranges(input int preset);
        range_bank_t bank;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        bank = '0;
        case (preset)
            PRESET_TYPICAL: begin
                bank[CFG_POSITION] = {32'h000C_8000, 32'hFFF3_8000};
                bank[CFG_SPEED]    = {32'h0041_0000, 32'hFFBF_0000};
                bank[CFG_KP]       = {32'h01F4_0000, 32'h0000_0000};
                bank[CFG_KD]       = {32'h0005_0000, 32'h0000_0000};
                bank[CFG_TORQUE]   = {32'h0012_0000, 32'hFFEE_0000};
            end
            PRESET_FULL: begin
                for (int i = int'(CFG_POSITION); i <= int'(CFG_TORQUE); i++)
                    bank[i] = {VAL_MAX, VAL_MIN};
            end
            PRESET_DEGENERATE: begin
                // inverted, empty, one lsb wide, at the top edge, all ones
                bank[CFG_POSITION] = {32'hFFFF_0000, 32'h0001_0000};
                bank[CFG_SPEED]    = {32'h0005_0000, 32'h0005_0000};
                bank[CFG_KP]       = {32'h0000_0001, 32'h0000_0000};
                bank[CFG_KD]       = {VAL_MAX, 32'h7FFF_FFFE};
                bank[CFG_TORQUE]   = '1;
            end
            PRESET_RANDOM: begin
                for (int i = int'(CFG_POSITION); i <= int'(CFG_TORQUE); i++) begin
                    a = $urandom;
                    b = $urandom;
                    case ($urandom_range(0, 3))
                        0: bank[i] = {a, b};
                        1: bank[i] = ($signed(a) > $signed(b)) ? {a, b} : {b, a};
                        default: begin
                            a = a >> $urandom_range(1, 24);
                            bank[i] = {a, -a};
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return bank;
    endfunction

    // mostly values around the configured range, some raw and extreme ones
    function automatic logic [VAL_W-1:0] draw_value(input logic [CFG_W-1:0] rng,
                                                    input bit negated);
        longint lo;
        longint hi;
        longint span;
        longint x;
        longint unsigned rnd;
        lo  = $signed(rng[VAL_W-1:0]);
        hi  = $signed(rng[CFG_W-1:VAL_W]);
        rnd = {$urandom, $urandom};
        span = hi - lo;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            2: x = lo;
            3: x = hi;
            default: begin
                if (hi <= lo)
                    return $urandom;
                x = lo - span / 8 + longint'(rnd % longint'(span + span / 4 + 1));
            end
        endcase
        if (negated)
            x = -x;
        return x[VAL_W-1:0];
    endfunction

    function automatic cmd_request_t random_request();
        cmd_request_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.op = OP_CONTROL;
        else if (pick < 75)
            r.op = OP_RESEND;
        else if (pick < 80)
            r.op = OP_ENTER;
        else if (pick < 85)
            r.op = OP_EXIT;
        else if (pick < 90)
            r.op = OP_ZERO;
        else
            r.op = OP_W'($urandom_range(int'(OP_SPARE_LOW), int'(OP_SPARE_TOP)));
        r.id   = ID_W'($urandom);
        r.slot = SLOT_W'($urandom);
        r.pos  = draw_value(range_regs[CFG_POSITION], 1'b1);
        r.spd  = draw_value(range_regs[CFG_SPEED], 1'b1);
        r.kp   = draw_value(range_regs[CFG_KP], 1'b0);
        r.kd   = draw_value(range_regs[CFG_KD], 1'b0);
        r.trq  = draw_value(range_regs[CFG_TORQUE], 1'b1);
        return r;
    endfunction

    function automatic void add_row(input int preset, input logic [OP_W-1:0] op,
                                    input logic [ID_W-1:0] id,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic [VAL_W-1:0] pos, input logic [VAL_W-1:0] spd,
                                    input logic [VAL_W-1:0] kp, input logic [VAL_W-1:0] kd,
                                    input logic [VAL_W-1:0] trq);
        directed_row_t row;
        row.preset   = preset;
        row.req.op   = op;
        row.req.id   = id;
        row.req.slot = slot;
        row.req.pos  = pos;
        row.req.spd  = spd;
        row.req.kp   = kp;
        row.req.kd   = kd;
        row.req.trq  = trq;
        row.typed    = 1'b0;
        directed.push_back(row);
    endfunction

    // pins the frame expected from the row just added
    function automatic void type_result(input logic [ID_W-1:0] id,
                                        input logic [DATA_W-1:0] data, input logic flag);
        int last;
        last = directed.size() - 1;
        directed[last].typed        = 1'b1;
        directed[last].want.id      = id;
        directed[last].want.data    = data;
        directed[last].want.no_prev = flag;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_frame();
        frame_t want;
        n_checked++;
        if (m_no_previous === 1'b1)
            n_misses++;
        if (pending_frames.size() == 0) begin
            note_mismatch($sformatf("frame with nothing pending: id %h data %h flag %b",
                                    m_frame_id, m_frame_data, m_no_previous));
            return;
        end
        want = pending_frames.pop_front();
        if (m_frame_id !== want.id)
            note_mismatch($sformatf("frame_id %h, want %h", m_frame_id, want.id));
        if (m_frame_data !== want.data)
            note_mismatch($sformatf("frame_data %h, want %h", m_frame_data, want.data));
        if (m_no_previous !== want.no_prev)
            note_mismatch($sformatf("no_previous %b, want %b", m_no_previous, want.no_prev));
    endtask

    task automatic issue_request(input cmd_request_t r, input bit typed,
                                 input frame_t typed_frame);
        int gap;
        frame_t f;
        gap = send_eager ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= r.op;
        s_motor_id       <= r.id;
        s_motor_slot     <= r.slot;
        s_goal_position  <= r.pos;
        s_goal_speed     <= r.spd;
        s_stiffness_gain <= r.kp;
        s_damping_gain   <= r.kd;
        s_goal_torque    <= r.trq;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        n_requests++;
        if (predict_frame(r, f))
            pending_frames.push_back(typed ? typed_frame : f);
        case (r.op) inside
            OP_CONTROL: n_control++;
            OP_RESEND:  n_resend++;
            OP_ENTER, OP_EXIT, OP_ZERO: n_fixed++;
            default:    n_ignored++;
        endcase
    endtask

    // hold off until every pending frame is back, then let the block finish
    task automatic settle(input int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic load_ranges(input range_bank_t bank);
        for (int i = int'(CFG_POSITION); i <= int'(CFG_TORQUE); i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFGIX_W'(i);
            cfg_data  <= bank[i];
            range_regs[i] = bank[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = take_eager ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_ready <= 1'b0;
                // half the stalls land on a frame already waiting
                if ($urandom_range(0, 1)) begin
                    @(posedge aclk);
                    while (m_valid !== 1'b1) @(posedge aclk);
                end
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            check_frame();
        end
    end

    initial begin : stimulus
        cmd_request_t req;
        frame_t       no_frame;
        int           counted;
        int           preset;

        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_op             <= OP_CONTROL;
        s_motor_id       <= '0;
        s_motor_slot     <= '0;
        s_goal_position  <= '0;
        s_goal_speed     <= '0;
        s_stiffness_gain <= '0;
        s_damping_gain   <= '0;
        s_goal_torque    <= '0;
        no_frame.id      = '0;
        no_frame.data    = '0;
        no_frame.no_prev = 1'b0;

        // ranges still at reset: every control code is zero
        add_row(KEEP_RANGES, OP_RESEND, 11'h123, 4'd3, '0, '0, '0, '0, '0);
        type_result(11'h123, '0, 1'b1);
        add_row(KEEP_RANGES, OP_CONTROL, 11'h7FF, 4'd0, VAL_MIN, VAL_MAX, VAL_MIN,
                VAL_MAX, VAL_MIN);
        type_result(11'h7FF, '0, 1'b0);
        add_row(KEEP_RANGES, OP_RESEND, 11'h000, 4'd0, '0, '0, '0, '0, '0);
        type_result(11'h7FF, '0, 1'b0);
        add_row(KEEP_RANGES, OP_RESEND, 11'h055, 4'd0, '0, '0, '0, '0, '0);
        type_result(11'h055, '0, 1'b1);
        add_row(KEEP_RANGES, OP_ENTER, 11'h001, 4'hF, '1, '1, '1, '1, '1);
        type_result(11'h001, FRAME_ENTER, 1'b0);
        add_row(KEEP_RANGES, OP_EXIT, 11'h400, 4'h8, '0, '0, '0, '0, '0);
        type_result(11'h400, FRAME_EXIT, 1'b0);
        add_row(KEEP_RANGES, OP_ZERO, 11'h2AA, 4'h5, VAL_MAX, VAL_MAX, VAL_MAX,
                VAL_MAX, VAL_MAX);
        type_result(11'h2AA, FRAME_ZERO, 1'b0);
        add_row(KEEP_RANGES, OP_SPARE_TOP, 11'h5A5, 4'hA, '1, '1, '1, '1, '1);

        add_row(PRESET_TYPICAL, OP_CONTROL, 11'h3FF, 4'hF, '0, '0, '0, '0, '0);
        add_row(KEEP_RANGES, OP_CONTROL, 11'h10A, 4'd1, 32'h0001_8000, 32'hFFF6_0000,
                32'h0064_0000, 32'h0002_8000, 32'h0003_0000);
        add_row(KEEP_RANGES, OP_CONTROL, 11'h20B, 4'd2, VAL_MAX, VAL_MIN, VAL_MIN,
                VAL_MAX, VAL_MIN);
        // values sitting exactly on the range bounds
        add_row(KEEP_RANGES, OP_CONTROL, 11'h20C, 4'd2, 32'h000C_8000, 32'hFFBF_0000,
                32'h01F4_0000, 32'h0000_0000, 32'h0012_0000);
        add_row(KEEP_RANGES, OP_RESEND, 11'h000, 4'd2, '0, '0, '0, '0, '0);
        add_row(KEEP_RANGES, OP_RESEND, 11'h7FF, 4'd1, '0, '0, '0, '0, '0);
        add_row(KEEP_RANGES, OP_RESEND, 11'h001, 4'hF, '0, '0, '0, '0, '0);

        // full signed span: the negated minimum clamps to the top code
        add_row(PRESET_FULL, OP_CONTROL, 11'h6C3, 4'd4, VAL_MIN, VAL_MIN, VAL_MIN,
                VAL_MIN, VAL_MIN);
        type_result(11'h6C3, 64'hFFFF_FFF0_0000_0FFF, 1'b0);
        add_row(KEEP_RANGES, OP_CONTROL, 11'h13C, 4'd5, VAL_MAX, VAL_MAX, VAL_MAX,
                VAL_MAX, VAL_MAX);
        type_result(11'h13C, 64'h0000_000F_FFFF_F000, 1'b0);
        add_row(KEEP_RANGES, OP_CONTROL, 11'h2D2, 4'd6, '0, '0, '0, '0, '0);
        add_row(KEEP_RANGES, OP_RESEND, 11'h000, 4'd4, '0, '0, '0, '0, '0);
        type_result(11'h6C3, 64'hFFFF_FFF0_0000_0FFF, 1'b0);

        add_row(PRESET_DEGENERATE, OP_CONTROL, 11'h0F0, 4'd7, 32'h0000_8000,
                32'h0005_0000, 32'h0000_0001, VAL_MAX, 32'h1234_5678);
        add_row(KEEP_RANGES, OP_CONTROL, 11'h70F, 4'd8, 32'hFFFF_8000, 32'hFFFB_0000,
                32'h0000_0000, 32'h7FFF_FFFE, VAL_MIN);
        add_row(KEEP_RANGES, OP_RESEND, 11'h333, 4'd7, '0, '0, '0, '0, '0);
        add_row(KEEP_RANGES, OP_SPARE_LOW, 11'h2A5, 4'h6, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        add_row(KEEP_RANGES, OP_RESEND, 11'h4CC, 4'd9, '0, '0, '0, '0, '0);
        type_result(11'h4CC, '0, 1'b1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].preset != KEEP_RANGES) begin
                settle(DRAIN_CYCLES);
                load_ranges(preset_ranges(directed[i].preset));
            end
            issue_request(directed[i].req, directed[i].typed, directed[i].want);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       preset = PRESET_TYPICAL;
                1:       preset = PRESET_FULL;
                4:       preset = PRESET_DEGENERATE;
                default: preset = PRESET_RANDOM;
            endcase
            settle(DRAIN_CYCLES);
            load_ranges(preset_ranges(preset));
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                // occasional runs with no idle on one side or both
                if (counted % 16 == 0) begin
                    send_eager = $urandom_range(0, 3) == 0;
                    take_eager = $urandom_range(0, 3) == 0;
                end
                req = random_request();
                issue_request(req, 1'b0, no_frame);
                if (req.op <= OP_RESEND)
                    counted++;
                if ($urandom_range(0, 39) == 0)
                    settle(1);
            end
        end

        settle(DRAIN_CYCLES);
        $display("covered %0d requests: %0d control, %0d resend, %0d fixed, %0d ignored",
                 n_requests, n_control, n_resend, n_fixed, n_ignored);
        $display("%0d frames checked, %0d resend misses, %0d range settings, %0d mismatches",
                 n_checked, n_misses, n_settings, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
